// ===== hw/rtl/crcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared constants, types and codes of the CRC-8 checked frame parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

	// Largest payload a frame may carry.
	localparam int MAX_PAYLOAD = 16;

	// Counter wide enough to hold MAX_PAYLOAD itself, and a store address.
	localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// Fixed field widths of one result beat.
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int INDEX_W = 4;
	localparam int OUT_W   = 3 * BYTE_W + LEN_W + INDEX_W;
	localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

	// CRC-8 generator polynomial x^8 + x^2 + x + 1, MSB first.
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION_BYTE = 2'd2;

	// Position of the parser inside a frame.
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_VERSION = 3'd2,
		PH_TYPE    = 3'd3,
		PH_SEQ     = 3'd4,
		PH_LEN     = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_CRC     = 3'd7
	} phase_t;

	// Sequencer state of the top level.
	typedef enum logic [1:0] {
		CT_IDLE = 2'd0,
		CT_CRC  = 2'd1,
		CT_READ = 2'd2,
		CT_SHOW = 2'd3
	} ctl_t;

	// Commands to the bit-serial CRC unit.
	typedef struct packed {
		logic start;
		logic clear;
	} crc_ctrl_t;

endpackage

// ===== hw/rtl/crcfp_ram.sv =====
// ----------------------------------------------------------------------------
// crcfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/crcfp_crc.sv =====
// ----------------------------------------------------------------------------
// crcfp_crc
// Bit-serial CRC-8 engine: folds in one byte, then shifts it out one bit at a time.
// ----------------------------------------------------------------------------
module crcfp_crc
	import crcfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  crc_ctrl_t         ctrl,
	input  logic [BYTE_W-1:0] data,
	output logic [BYTE_W-1:0] crc,
	output logic              busy
);

	logic [BYTE_W-1:0] crc_q;
	logic [2:0]        bit_q;
	logic              busy_q;
	logic [BYTE_W-1:0] shifted;

	// One step of the division: shift left, subtract the polynomial on carry-out.
	assign shifted = crc_q[BYTE_W-1] ? ({crc_q[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
	                                 : {crc_q[BYTE_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctrl.clear) begin
			crc_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctrl.start) begin
			crc_q  <= crc_q ^ data;
			bit_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= shifted;
			bit_q <= bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign crc  = crc_q;
	assign busy = busy_q;

endmodule

// ===== hw/rtl/crc8_checked_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// crc8_checked_frame_parser_top
// Sync hunt, header capture and CRC-8 check of framed serial bytes.
// ----------------------------------------------------------------------------
// A byte covered by the CRC holds the input: after it is accepted, the
// sequencer waits in CT_CRC until the bit-serial CRC unit has shifted it in
// and drops its busy flag. Sync bytes, rejected bytes and the CRC byte do not.
// A matching CRC byte sends the sequencer through CT_READ (payload RAM read)
// to CT_SHOW for the first result beat, and again after each beat taken that is not the last.
// arst_n clears the parser, the configuration registers and the output valid.
module crc8_checked_frame_parser_top
	import crcfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Received bytes. Fields from bit 0: rx_byte[7:0].
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,
	// Result beats. Fields from bit 0: msg_type[7:0], seq_num[15:8],
	// payload_len[20:16], byte_index[24:21], payload_byte[32:25], zeros above.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,
	// last_of_frame.
	output logic                 m_tlast,
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [BYTE_W-1:0] version_q;

	// Parser state.
	phase_t            phase_q;
	ctl_t              ctl_q;
	ctl_t              ctl_next;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] seq_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] index_q;

	// Handshakes and decode of the incoming byte.
	logic              in_beat;
	logic              out_beat;
	logic              feed;
	logic              restart;
	logic              emit_go;
	logic              last_beat;
	logic              len_ok;
	logic [CNT_W-1:0]  fill_inc;
	logic [CNT_W-1:0]  index_inc;

	// CRC unit and payload store.
	crc_ctrl_t         crc_ctrl;
	logic [BYTE_W-1:0] crc_val;
	logic              crc_busy;
	logic              ram_we;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] payload_out;

	assign cfg_ready = 1'b1;
	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
			version_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SYNC_FIRST:   sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND:  sync_second_q <= cfg_data;
				CFG_VERSION_BYTE: version_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A length above the payload limit aborts the frame.
	assign len_ok    = (s_tdata <= BYTE_W'(MAX_PAYLOAD));
	assign fill_inc  = fill_q + CNT_W'(1);
	assign index_inc = CNT_W'(index_q) + CNT_W'(1);

	// An empty frame still yields one beat; otherwise the beat at len - 1 is last.
	assign last_beat = (len_q == '0) || (index_inc == len_q);

	// Bytes that enter the CRC: a good version, type, sequence, a good length
	// and every payload byte.
	always_comb begin
		feed    = 1'b0;
		restart = 1'b0;
		emit_go = 1'b0;
		if (in_beat) begin
			case (phase_q)
				PH_VERSION: begin
					feed    = (s_tdata == version_q);
					restart = (s_tdata != version_q);
				end
				PH_TYPE:    feed = 1'b1;
				PH_SEQ:     feed = 1'b1;
				PH_LEN: begin
					feed    = len_ok;
					restart = !len_ok;
				end
				PH_PAYLOAD: feed = 1'b1;
				PH_CRC: begin
					// A bad check byte drops the frame without any beat.
					emit_go = (s_tdata == crc_val);
					restart = (s_tdata != crc_val);
				end
				default: ;
			endcase
		end
		if (out_beat && last_beat) begin
			restart = 1'b1;
		end
	end

	// Sequencer next state.
	always_comb begin
		ctl_next = ctl_q;
		case (ctl_q)
			CT_IDLE: begin
				if (feed) begin
					ctl_next = CT_CRC;
				end else if (emit_go) begin
					ctl_next = CT_READ;
				end
			end
			CT_CRC: begin
				if (!crc_busy) begin
					ctl_next = CT_IDLE;
				end
			end
			CT_READ:    ctl_next = CT_SHOW;
			CT_SHOW: begin
				if (m_tready) begin
					ctl_next = last_beat ? CT_IDLE : CT_READ;
				end
			end
			default:    ctl_next = CT_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready       = 1'b0;
		m_tvalid       = 1'b0;
		ram_re         = 1'b0;
		crc_ctrl.start = feed;
		crc_ctrl.clear = restart;
		case (ctl_q)
			CT_IDLE:    s_tready = 1'b1;
			CT_CRC:     ;
			CT_READ:    ram_re   = 1'b1;
			CT_SHOW:    m_tvalid = 1'b1;
			default:    ;
		endcase
	end

	assign ram_we = in_beat && (phase_q == PH_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CT_IDLE;
			phase_q <= PH_SYNC1;
			type_q  <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			index_q <= '0;
		end else begin
			ctl_q <= ctl_next;
			if (restart) begin
				phase_q <= PH_SYNC1;
				type_q  <= '0;
				seq_q   <= '0;
				len_q   <= '0;
				fill_q  <= '0;
				index_q <= '0;
			end else begin
				if (out_beat) begin
					index_q <= index_q + ADDR_W'(1);
				end
				if (in_beat) begin
					case (phase_q)
						PH_SYNC1: begin
							if (s_tdata == sync_first_q) begin
								phase_q <= PH_SYNC2;
							end
						end
						PH_SYNC2: begin
							// A repeated first sync byte keeps the hunt armed.
							if (s_tdata == sync_second_q) begin
								phase_q <= PH_VERSION;
							end else if (s_tdata != sync_first_q) begin
								phase_q <= PH_SYNC1;
							end
						end
						PH_VERSION: phase_q <= PH_TYPE;
						PH_TYPE: begin
							type_q  <= s_tdata;
							phase_q <= PH_SEQ;
						end
						PH_SEQ: begin
							seq_q   <= s_tdata;
							phase_q <= PH_LEN;
						end
						PH_LEN: begin
							len_q   <= CNT_W'(s_tdata);
							fill_q  <= '0;
							index_q <= '0;
							phase_q <= (s_tdata == '0) ? PH_CRC : PH_PAYLOAD;
						end
						PH_PAYLOAD: begin
							fill_q <= fill_inc;
							if (fill_inc >= len_q) begin
								phase_q <= PH_CRC;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	crcfp_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (s_tdata),
		.crc    (crc_val),
		.busy   (crc_busy)
	);

	crcfp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (index_q),
		.rdata (ram_rdata)
	);

	// An empty frame reports a zero payload byte; its store entry is never valid.
	assign payload_out = (len_q == '0) ? '0 : ram_rdata;

	assign m_tdata = {
		(TDATA_W - OUT_W)'(0),
		payload_out,
		INDEX_W'(index_q),
		LEN_W'(len_q),
		seq_q,
		type_q
	};
	assign m_tlast = last_beat;

endmodule

// ===== hw/rtl/crcfp_checker.sv =====
// ----------------------------------------------------------------------------
// crcfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module crcfp_checker
	import crcfp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TDATA_W-1:0]   m_tdata,
	input logic                 m_tlast
);

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// No byte is taken while a result beat is pending.
	a_no_rx_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result beat is pending");

	// An empty frame is a single last beat with zero index and payload.
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:16] == 5'd0) |-> m_tlast && (m_tdata[32:21] == 12'd0))
		else $error("empty frame beat malformed");

	// The final beat of a frame is followed by a gap.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("beat right after the last beat of a frame");

endmodule

bind crc8_checked_frame_parser_top crcfp_checker u_checker (.*);

// ===== tb/sv/crc8_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_checker
// Watches the byte, result and configuration channels of the frame parser,
// predicts the result beats of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
module crc8_frame_checker
	import crcfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [TDATA_W-1:0]   m_tdata,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output int                   expected_left,
	output int                   mismatches
);

	localparam int REPORT_LINES = 60;

	typedef struct packed {
		logic [BYTE_W-1:0]  msg_type;
		logic [BYTE_W-1:0]  seq_num;
		logic [LEN_W-1:0]   payload_len;
		logic [INDEX_W-1:0] byte_index;
		logic [BYTE_W-1:0]  payload_byte;
		logic               last_of_frame;
	} frame_beat_t;

	frame_beat_t       beats_q[$];

	logic [BYTE_W-1:0] sync_first_r;
	logic [BYTE_W-1:0] sync_second_r;
	logic [BYTE_W-1:0] version_r;

	phase_t            phase;
	logic [BYTE_W-1:0] hold_type;
	logic [BYTE_W-1:0] hold_seq;
	logic [LEN_W-1:0]  hold_len;
	logic [CNT_W-1:0]  fill_cnt;
	logic [BYTE_W-1:0] store [MAX_PAYLOAD];
	logic [BYTE_W-1:0] crc_acc;

	function automatic logic [BYTE_W-1:0] crc8_step(logic [BYTE_W-1:0] crc,
			logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_LINES) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	task automatic restart_parse();
		phase     = PH_SYNC1;
		hold_type = '0;
		hold_seq  = '0;
		hold_len  = '0;
		fill_cnt  = '0;
		crc_acc   = '0;
	endtask

	// A frame whose check byte matches gives one beat per payload byte, or a
	// single empty beat when the length was zero.
	task automatic emit_frame();
		frame_beat_t beat;
		int          count;
		count = (hold_len == 0) ? 1 : int'(hold_len);
		for (int k = 0; k < count; k++) begin
			beat.msg_type      = hold_type;
			beat.seq_num       = hold_seq;
			beat.payload_len   = hold_len;
			beat.byte_index    = k[INDEX_W-1:0];
			beat.payload_byte  = (hold_len != 0) ? store[k] : '0;
			beat.last_of_frame = (k == count - 1);
			beats_q.push_back(beat);
		end
	endtask

	task automatic take_byte(logic [BYTE_W-1:0] b);
		case (phase)
			PH_SYNC1: begin
				if (b == sync_first_r) phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b == sync_second_r) phase = PH_VERSION;
				else if (b != sync_first_r) phase = PH_SYNC1;
			end
			PH_VERSION: begin
				if (b != version_r) begin
					restart_parse();
				end else begin
					crc_acc = crc8_step('0, b);
					phase   = PH_TYPE;
				end
			end
			PH_TYPE: begin
				hold_type = b;
				crc_acc   = crc8_step(crc_acc, b);
				phase     = PH_SEQ;
			end
			PH_SEQ: begin
				hold_seq = b;
				crc_acc  = crc8_step(crc_acc, b);
				phase    = PH_LEN;
			end
			PH_LEN: begin
				if (int'(b) > MAX_PAYLOAD) begin
					restart_parse();
				end else begin
					hold_len = b[LEN_W-1:0];
					fill_cnt = '0;
					crc_acc  = crc8_step(crc_acc, b);
					phase    = (b == 0) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (int'(fill_cnt) < MAX_PAYLOAD) store[fill_cnt[ADDR_W-1:0]] = b;
				fill_cnt = fill_cnt + CNT_W'(1);
				crc_acc  = crc8_step(crc_acc, b);
				if (fill_cnt >= hold_len) phase = PH_CRC;
			end
			default: begin
				if (b == crc_acc) emit_frame();
				restart_parse();
			end
		endcase
	endtask

	task automatic check_beat();
		frame_beat_t want;
		if (beats_q.size() == 0) begin
			report_mismatch($sformatf("result beat 0x%0h with no frame pending", m_tdata));
		end else begin
			want = beats_q.pop_front();
			compare_field("msg_type", int'(m_tdata[7:0]), int'(want.msg_type));
			compare_field("seq_num", int'(m_tdata[15:8]), int'(want.seq_num));
			compare_field("payload_len", int'(m_tdata[20:16]), int'(want.payload_len));
			compare_field("byte_index", int'(m_tdata[24:21]), int'(want.byte_index));
			compare_field("payload_byte", int'(m_tdata[32:25]), int'(want.payload_byte));
			compare_field("tdata padding", int'(m_tdata[TDATA_W-1:OUT_W]), 0);
			compare_field("last_of_frame", int'(m_tlast), int'(want.last_of_frame));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_r  = '0;
			sync_second_r = '0;
			version_r     = '0;
			restart_parse();
			beats_q.delete();
			mismatches    = 0;
			expected_left <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SYNC_FIRST:   sync_first_r  = cfg_data;
					CFG_SYNC_SECOND:  sync_second_r = cfg_data;
					CFG_VERSION_BYTE: version_r     = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) take_byte(s_tdata);
			if (m_tvalid && m_tready) check_beat();
			expected_left <= beats_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_crc8_checked_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc8_checked_frame_parser_top
// Drives framed serial bytes into the CRC-8 frame parser under several sync
// and version settings and lets a checker compare every result beat.
// ----------------------------------------------------------------------------
// The stimulus opens with a few hand-built frames covering the corner cases of
// the parser, then sends random frames, most of them well formed, mixed with
// bad check bytes, wrong versions, over-long lengths, cut-off frames and line
// noise. The checker beside the block predicts and compares; this module only
// makes stimulus, paces both sides of the stream and gives the verdict.
module tb_crc8_checked_frame_parser_top;
	import crcfp_pkg::*;

	// A long hold-off of the result side must fit well inside the watchdog.
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int CFG_SETTLE   = 16;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_BYTES  = 90;

	// Ways the result side paces its ready.
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_ONE_IN_FOUR,
		RX_MOSTLY
	} rx_mode_t;

	// Shapes of the random frames.
	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_VERSION,
		FR_OVERLONG,
		FR_CUT,
		FR_RESYNC,
		FR_NOISE
	} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	int                   expected_left;
	int                   mismatches;

	// Sender bookkeeping: the bytes of the frame being built, its running
	// check value, and the settings the frames are built for.
	logic [BYTE_W-1:0]    frame_q[$];
	logic [BYTE_W-1:0]    frame_crc;
	logic [BYTE_W-1:0]    sync1;
	logic [BYTE_W-1:0]    sync2;
	logic [BYTE_W-1:0]    ver;
	int                   burst_left;
	int                   frame_bytes;

	// The sender asks for a long hold-off by bumping this count.
	int                   hold_ask = 0;
	int                   idle_cycles = 0;

	always #2 clk = ~clk;

	crc8_checked_frame_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crc8_frame_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.expected_left (expected_left),
		.mismatches    (mismatches)
	);

	// The frame builder needs the same CRC-8 (polynomial 0x07, MSB first) to
	// produce check bytes that the block will accept.
	function automatic logic [BYTE_W-1:0] crc8_add(logic [BYTE_W-1:0] crc,
			logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	// Mostly short payloads so that frames stay quick, now and then the
	// largest one the block takes.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, 4);
		if (r < 8) return $urandom_range(5, MAX_PAYLOAD - 1);
		return MAX_PAYLOAD;
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return FR_GOOD;
		if (r < 65) return FR_BAD_CRC;
		if (r < 70) return FR_BAD_VERSION;
		if (r < 75) return FR_OVERLONG;
		if (r < 80) return FR_CUT;
		if (r < 88) return FR_RESYNC;
		return FR_NOISE;
	endfunction

	// Offers one byte and waits for its beat. The sender works in bursts of
	// random length; between bursts tvalid drops for a random gap, and some
	// bursts follow with no gap at all. On return we stand at a falling edge
	// with tvalid still high, so a following byte never toggles it in one step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic put_byte(input logic [BYTE_W-1:0] b, input bit covered);
		frame_q.push_back(b);
		if (covered) frame_crc = crc8_add(frame_crc, b);
	endtask

	// Sync pair, version, type, sequence and length; the check value starts
	// over at the version byte.
	task automatic build_header(input logic [BYTE_W-1:0] typ, seq, len_b);
		frame_crc = '0;
		put_byte(sync1, 1'b0);
		put_byte(sync2, 1'b0);
		put_byte(ver, 1'b1);
		put_byte(typ, 1'b1);
		put_byte(seq, 1'b1);
		put_byte(len_b, 1'b1);
	endtask

	// A complete frame with random header and payload. A bad check byte is
	// the right one with at least one bit flipped.
	task automatic build_frame(input bit crc_good);
		int len;
		len = pick_len();
		build_header(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
			BYTE_W'(len));
		for (int i = 0; i < len; i++) put_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
		put_byte(crc_good ? frame_crc : frame_crc ^ BYTE_W'($urandom_range(1, 255)), 1'b0);
	endtask

	task automatic send_queued();
		while (frame_q.size() > 0) begin
			send_byte(frame_q.pop_front());
			frame_bytes++;
		end
	endtask

	// Drops tvalid and waits until every predicted beat has been taken.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_left != 0) @(negedge clk);
	endtask

	// Registers change only with the block idle: nothing pending, and enough
	// quiet cycles for a byte still inside the bit-serial CRC unit to finish.
	task automatic load_config(input logic [BYTE_W-1:0] s1, s2, v);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [BYTE_W-1:0]    val [3];
		idx = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_VERSION_BYTE};
		val = '{s1, s2, v};
		wait_drained();
		repeat (CFG_SETTLE) @(negedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		sync1 = s1;
		sync2 = s2;
		ver   = v;
	endtask

	// One setting's worth of random frames. It opens with a long hold-off on
	// the result side while frames keep coming, so the block fills up and has
	// to hold its input; now and then the sender waits for a full drain.
	task automatic run_phase(input int n_bytes);
		int          stop_at;
		int          cut;
		frame_kind_t kind;
		stop_at = frame_bytes + n_bytes;
		hold_ask++;
		while (frame_bytes < stop_at) begin
			kind = pick_kind();
			case (kind)
				FR_GOOD: begin
					build_frame(1'b1);
				end
				FR_BAD_CRC: begin
					build_frame(1'b0);
				end
				FR_BAD_VERSION: begin
					put_byte(sync1, 1'b0);
					put_byte(sync2, 1'b0);
					put_byte(ver ^ BYTE_W'($urandom_range(1, 255)), 1'b0);
				end
				FR_OVERLONG: begin
					build_header(BYTE_W'($urandom_range(0, 255)),
						BYTE_W'($urandom_range(0, 255)),
						BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
				end
				FR_CUT: begin
					// The leftover parser state swallows the start of
					// whatever follows.
					build_frame(1'b1);
					cut = $urandom_range(1, frame_q.size() - 3);
					repeat (cut) void'(frame_q.pop_back());
				end
				FR_RESYNC: begin
					// Extra copies of the first sync byte keep the hunt armed.
					repeat ($urandom_range(1, 3)) put_byte(sync1, 1'b0);
					build_frame(1'b1);
				end
				default: begin
					// Line noise is mostly ignored by the hunt and is not
					// counted toward the phase.
					repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
				end
			endcase
			send_queued();
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
	endtask

	// Result side: a long hold-off when the sender asks for one, otherwise a
	// pacing mode that is picked anew at random whenever its span runs out, from always ready down
	// to one cycle in four.
	initial begin
		int       hold_seen;
		int       hold_left;
		int       mode_left;
		int       tick;
		rx_mode_t rx_mode;
		hold_seen = 0;
		hold_left = 0;
		mode_left = 0;
		tick      = 0;
		rx_mode   = RX_ALWAYS;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				tick++;
				case (rx_mode)
					RX_ALWAYS:      m_tready <= 1'b1;
					RX_COIN:        m_tready <= ($urandom_range(0, 1) != 0);
					RX_ONE_IN_FOUR: m_tready <= (tick % 4 == 0);
					default:        m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Watchdog: any run of cycles with no beat on any channel that outlasts
	// the longest legal pause means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("crc8_checked_frame_parser_top: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_SYNC_FIRST;
		cfg_data    = '0;
		sync1       = '0;
		sync2       = '0;
		ver         = '0;
		frame_crc   = '0;
		burst_left  = 0;
		frame_bytes = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_config(8'hA5, 8'h5A, 8'h01);

		// Empty frame behind a repeated first sync byte, with the type at its
		// lowest and the sequence at its highest value.
		frame_crc = '0;
		put_byte(sync1, 1'b0);
		put_byte(sync1, 1'b0);
		put_byte(sync2, 1'b0);
		put_byte(ver, 1'b1);
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b1);
		put_byte(8'h00, 1'b1);
		put_byte(frame_crc, 1'b0);
		// Wrong version byte: the hunt starts over.
		put_byte(sync1, 1'b0);
		put_byte(sync2, 1'b0);
		put_byte(ver ^ 8'h80, 1'b0);
		// Length one above the largest payload: the hunt starts over.
		build_header(8'h12, 8'h34, BYTE_W'(MAX_PAYLOAD + 1));
		// One-byte frame with a corrupted check byte is dropped silently.
		build_header(8'hFF, 8'h00, 8'd1);
		put_byte(8'hFF, 1'b1);
		put_byte(frame_crc ^ 8'h01, 1'b0);
		send_queued();

		run_phase(PHASE_BYTES);
		load_config(8'h00, 8'h00, 8'h00);
		run_phase(PHASE_BYTES);
		load_config(8'hFF, 8'hFF, 8'hFF);
		run_phase(PHASE_BYTES);
		load_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
			BYTE_W'($urandom_range(0, 255)));
		run_phase(PHASE_BYTES);

		// Let the last beats out, then give a stray beat time to show up.
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("crc8_checked_frame_parser_top: match");
		end else begin
			$display("crc8_checked_frame_parser_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== crc8_checked_frame_parser_top.f =====
hw/rtl/crcfp_pkg.sv
hw/rtl/crcfp_ram.sv
hw/rtl/crcfp_crc.sv
hw/rtl/crc8_checked_frame_parser_top.sv
hw/rtl/crcfp_checker.sv
tb/sv/crc8_frame_checker.sv
tb/sv/tb_crc8_checked_frame_parser_top.sv
